// ===== rtl/core/night_color_temperature_schedule_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the night color temperature schedule
// Concurrent checks that fall away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NIGHT_COLOR_TEMPERATURE_SCHEDULE_DEFINES_SVH
`define NIGHT_COLOR_TEMPERATURE_SCHEDULE_DEFINES_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define NCTS_ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ncts: invariant violated");

// cons holds in the cycle after ante
`define NCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncts: next-cycle check violated");

`else

`define NCTS_ASSERT_HOLDS(label, clk, rst_n, expr)
`define NCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ncts_pkg.sv =====
// ----------------------------------------------------------------------------
// Night color temperature schedule package
// Shared types, register codes and constants.
// ----------------------------------------------------------------------------
package ncts_pkg;

    localparam int TIME_W   = 17;
    localparam int KELVIN_W = 15;
    localparam int RAMP_W   = 16;
    localparam int FRAC_W   = 17;
    localparam int QUOT_W   = 16;
    localparam int DIST_W   = 18;

    localparam logic [TIME_W-1:0]        DAY_SECONDS = 17'd86400;
    localparam logic signed [DIST_W-1:0] DAY_S       = 18'sd86400;
    localparam logic signed [DIST_W-1:0] HALF_DAY_S  = 18'sd43200;
    localparam logic [FRAC_W-1:0]        Q_ONE       = 17'd65536;
    localparam logic [KELVIN_W-1:0]      DISABLED_KELVIN = 15'd6500;

    localparam logic [1:0] SUN_NORMAL      = 2'd0;
    localparam logic [1:0] SUN_POLAR_DAY   = 2'd1;
    localparam logic [1:0] SUN_POLAR_NIGHT = 2'd2;
    localparam logic [1:0] SUN_UNKNOWN     = 2'd3;

    localparam int DIV_STAGES = QUOT_W;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam int REG_INDEX_W = 3;
    localparam int APB_AW      = REG_INDEX_W + 2;
    localparam int APB_DW      = 32;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_ENABLED,
        REG_MANUAL_MODE,
        REG_LOCATION_KNOWN,
        REG_FROM_TIME,
        REG_TO_TIME,
        REG_DAY_TEMPERATURE,
        REG_NIGHT_TEMPERATURE,
        REG_RAMP_SECONDS
    } t_reg_index;

    // How an item's fraction is produced. Before the last front step,
    // KIND_RAMP marks an item that follows the warm window.
    typedef enum logic [1:0] {
        KIND_NEUTRAL,
        KIND_ZERO,
        KIND_ONE,
        KIND_RAMP
    } t_kind;

    typedef struct packed {
        logic                  enabled;
        logic                  manual_mode;
        logic                  location_known;
        logic [TIME_W-1:0]     from_time;
        logic [TIME_W-1:0]     to_time;
        logic [KELVIN_W-1:0]   day_temperature;
        logic [KELVIN_W-1:0]   night_temperature;
        logic [RAMP_W-1:0]     ramp_seconds;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        enabled:           1'b0,
        manual_mode:       1'b0,
        location_known:    1'b0,
        from_time:         17'd72000,
        to_time:           17'd21600,
        day_temperature:   15'd6500,
        night_temperature: 15'd4000,
        ramp_seconds:      16'd3600
    };

    typedef struct packed {
        logic [TIME_W-1:0] now_time;
        logic [1:0]        sun_condition;
        logic [TIME_W-1:0] sunrise_time;
        logic [TIME_W-1:0] sunset_time;
    } t_in_item;

    typedef struct packed {
        logic [KELVIN_W-1:0] kelvin_out;
        logic [FRAC_W-1:0]   warm_fraction;
    } t_out_item;

    // classified beat between front and back; num is the ramp numerator
    typedef struct packed {
        t_kind             kind;
        logic [TIME_W-1:0] num;
    } t_mid_item;

    typedef struct packed {
        t_kind             kind;
        logic [QUOT_W-1:0] quot;
    } t_div_result;

endpackage

// ===== rtl/core/night_color_temperature_schedule.sv =====
// ----------------------------------------------------------------------------
// Night color temperature schedule
// Each beat carries the time of day, the sun condition and the sunrise and
// sunset times; each result beat carries the screen color temperature in
// kelvin and the warm fraction in Q1.16. The block takes one beat per clock
// while full is low and returns one result beat per clock as long as pop
// keeps up. On its way from push to the result ports a beat passes two front
// stages, the queue, the 16-stage ramp divider (one quotient bit per stage),
// the multiply stage and the result register. full rises when the four-entry
// queue is full and the second front stage holds a beat that cannot move on.
// Registers sit on the APB-style port at byte address 4*i: enabled,
// manual_mode, location_known, from_time, to_time, day_temperature,
// night_temperature, ramp_seconds. Write them only while no beat is in flight.
// ----------------------------------------------------------------------------
`include "night_color_temperature_schedule_defines.svh"

module night_color_temperature_schedule (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input queue side
    input  logic                          push,
    input  ncts_pkg::t_in_item            i_item,
    output logic                          full,
    // result queue side
    input  logic                          pop,
    output ncts_pkg::t_out_item           o_result,
    output logic                          empty,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ncts_pkg::APB_AW-1:0]   paddr,
    input  logic [ncts_pkg::APB_DW-1:0]   pwdata,
    output logic [ncts_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    ncts_pkg::t_cfg        r_cfg;
    ncts_pkg::t_reg_index  reg_index;
    logic                  cfg_write;

    logic                  q_push;
    ncts_pkg::t_mid_item   q_item_in;
    logic                  q_full;
    logic                  q_pop;
    ncts_pkg::t_mid_item   q_item_out;
    logic                  q_empty;

    // ------------------------------------------------------------------
    // Configuration registers: write on the access phase, read anytime
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = ncts_pkg::t_reg_index'(paddr[ncts_pkg::APB_AW-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ncts_pkg::CFG_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                ncts_pkg::REG_ENABLED:        r_cfg.enabled        <= pwdata[0];
                ncts_pkg::REG_MANUAL_MODE:    r_cfg.manual_mode    <= pwdata[0];
                ncts_pkg::REG_LOCATION_KNOWN: r_cfg.location_known <= pwdata[0];
                ncts_pkg::REG_FROM_TIME: begin
                    r_cfg.from_time <= pwdata[ncts_pkg::TIME_W-1:0];
                end
                ncts_pkg::REG_TO_TIME: begin
                    r_cfg.to_time <= pwdata[ncts_pkg::TIME_W-1:0];
                end
                ncts_pkg::REG_DAY_TEMPERATURE: begin
                    r_cfg.day_temperature <= pwdata[ncts_pkg::KELVIN_W-1:0];
                end
                ncts_pkg::REG_NIGHT_TEMPERATURE: begin
                    r_cfg.night_temperature <= pwdata[ncts_pkg::KELVIN_W-1:0];
                end
                ncts_pkg::REG_RAMP_SECONDS: begin
                    r_cfg.ramp_seconds <= pwdata[ncts_pkg::RAMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            ncts_pkg::REG_ENABLED:        prdata = ncts_pkg::APB_DW'(r_cfg.enabled);
            ncts_pkg::REG_MANUAL_MODE:    prdata = ncts_pkg::APB_DW'(r_cfg.manual_mode);
            ncts_pkg::REG_LOCATION_KNOWN: prdata = ncts_pkg::APB_DW'(r_cfg.location_known);
            ncts_pkg::REG_FROM_TIME:      prdata = ncts_pkg::APB_DW'(r_cfg.from_time);
            ncts_pkg::REG_TO_TIME:        prdata = ncts_pkg::APB_DW'(r_cfg.to_time);
            ncts_pkg::REG_DAY_TEMPERATURE: begin
                prdata = ncts_pkg::APB_DW'(r_cfg.day_temperature);
            end
            ncts_pkg::REG_NIGHT_TEMPERATURE: begin
                prdata = ncts_pkg::APB_DW'(r_cfg.night_temperature);
            end
            ncts_pkg::REG_RAMP_SECONDS:   prdata = ncts_pkg::APB_DW'(r_cfg.ramp_seconds);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: reduce times mod one day, measure distances to both window
    // ends, settle zero / one / neutral or hand a ramp numerator on
    // ------------------------------------------------------------------
    ncts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_item_in)
    );

    // ------------------------------------------------------------------
    // Queue: lets the front keep taking beats while the back stalls
    // ------------------------------------------------------------------
    ncts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_item_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item_out),
        .o_empty (q_empty)
    );

    // ------------------------------------------------------------------
    // Back: divide the ramp numerator by the ramp length, interpolate
    // between day and night kelvin, hold the result beat for pop
    // ------------------------------------------------------------------
    ncts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_item  (q_item_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    // ------------------------------------------------------------------
    // Checks on the front / queue / back hand-off
    // ------------------------------------------------------------------
    `NCTS_ASSERT_HOLDS(a_q_push_room, i_clk, i_rst_n, !(q_push && q_full))
    `NCTS_ASSERT_HOLDS(a_q_pop_data, i_clk, i_rst_n, !(q_pop && q_empty))
    `NCTS_ASSERT_HOLDS(a_q_full_not_empty, i_clk, i_rst_n, !(q_full && q_empty))
    `NCTS_ASSERT_NEXT(a_q_full_holds, i_clk, i_rst_n, q_full && !q_pop, q_full)

endmodule

// ===== rtl/core/ncts_front.sv =====
// ----------------------------------------------------------------------------
// Night color temperature schedule: front
// Reduce times, measure distances to the window ends and classify each beat.
// ----------------------------------------------------------------------------
module ncts_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ncts_pkg::t_cfg      i_cfg,
    input  logic                i_push,
    input  ncts_pkg::t_in_item  i_item,
    output logic                o_full,
    input  logic                i_q_full,
    output logic                o_q_push,
    output ncts_pkg::t_mid_item o_q_item
);

    function automatic logic [ncts_pkg::TIME_W-1:0] mod_day(
        input logic [ncts_pkg::TIME_W-1:0] v
    );
        return (v >= ncts_pkg::DAY_SECONDS) ? v - ncts_pkg::DAY_SECONDS : v;
    endfunction

    // signed distance from base to t, in half-seconds, in (-12 h, 12 h]
    function automatic logic signed [ncts_pkg::DIST_W-1:0] half_dist(
        input logic [ncts_pkg::TIME_W-1:0] t,
        input logic [ncts_pkg::TIME_W-1:0] base
    );
        logic signed [ncts_pkg::DIST_W-1:0] diff;
        logic signed [ncts_pkg::DIST_W-1:0] wrapped;
        diff = $signed({1'b0, t}) - $signed({1'b0, base});
        if (diff > ncts_pkg::HALF_DAY_S) begin
            wrapped = diff - ncts_pkg::DAY_S;
        end else if (diff <= -ncts_pkg::HALF_DAY_S) begin
            wrapped = diff + ncts_pkg::DAY_S;
        end else begin
            wrapped = diff;
        end
        return wrapped <<< 1;
    endfunction

    function automatic logic in_window(
        input logic [ncts_pkg::TIME_W-1:0] t,
        input logic [ncts_pkg::TIME_W-1:0] s,
        input logic [ncts_pkg::TIME_W-1:0] e
    );
        if (s == e) begin
            return 1'b0;
        end else if (s < e) begin
            return (t >= s) && (t < e);
        end else begin
            return (t >= s) || (t < e);
        end
    endfunction

    logic                            front_adv;

    // stage A: reduced times and coarse class
    logic                            r_a_valid;
    ncts_pkg::t_kind                 r_a_kind;
    logic [ncts_pkg::TIME_W-1:0]     r_a_t;
    logic [ncts_pkg::TIME_W-1:0]     r_a_s;
    logic [ncts_pkg::TIME_W-1:0]     r_a_e;
    ncts_pkg::t_kind                 n_a_kind;
    logic [ncts_pkg::TIME_W-1:0]     n_a_t;
    logic [ncts_pkg::TIME_W-1:0]     n_a_s;
    logic [ncts_pkg::TIME_W-1:0]     n_a_e;

    // stage B: distances to both ends and the hard window flag
    logic                            r_b_valid;
    ncts_pkg::t_kind                 r_b_kind;
    logic signed [ncts_pkg::DIST_W-1:0] r_b_ds;
    logic signed [ncts_pkg::DIST_W-1:0] r_b_de;
    logic                            r_b_win;

    // last step, into the queue
    logic [ncts_pkg::TIME_W-1:0]     ramp_h;
    logic [ncts_pkg::TIME_W-1:0]     abs_s;
    logic [ncts_pkg::TIME_W-1:0]     abs_e;
    logic                            near_s;
    logic                            near_e;
    logic signed [ncts_pkg::DIST_W:0] sum_s;
    logic signed [ncts_pkg::DIST_W:0] sum_e;

    assign front_adv = !r_b_valid || !i_q_full;
    assign o_full    = !front_adv;
    assign o_q_push  = r_b_valid && !i_q_full;

    always_comb begin
        n_a_t    = mod_day(i_item.now_time);
        n_a_s    = mod_day(i_item.sunset_time);
        n_a_e    = mod_day(i_item.sunrise_time);
        n_a_kind = ncts_pkg::KIND_RAMP;
        if (!i_cfg.enabled) begin
            n_a_kind = ncts_pkg::KIND_NEUTRAL;
        end else if (i_cfg.manual_mode) begin
            n_a_s = mod_day(i_cfg.from_time);
            n_a_e = mod_day(i_cfg.to_time);
        end else if (!i_cfg.location_known) begin
            n_a_kind = ncts_pkg::KIND_ZERO;
        end else begin
            case (i_item.sun_condition)
                ncts_pkg::SUN_NORMAL:      n_a_kind = ncts_pkg::KIND_RAMP;
                ncts_pkg::SUN_POLAR_NIGHT: n_a_kind = ncts_pkg::KIND_ONE;
                ncts_pkg::SUN_POLAR_DAY:   n_a_kind = ncts_pkg::KIND_ZERO;
                default:                   n_a_kind = ncts_pkg::KIND_ZERO;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (front_adv) begin
            r_a_valid <= i_push;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_adv) begin
            r_a_kind <= n_a_kind;
            r_a_t    <= n_a_t;
            r_a_s    <= n_a_s;
            r_a_e    <= n_a_e;
            r_b_kind <= r_a_kind;
            r_b_ds   <= half_dist(r_a_t, r_a_s);
            r_b_de   <= half_dist(r_a_t, r_a_e);
            r_b_win  <= in_window(r_a_t, r_a_s, r_a_e);
        end
    end

    // half ramp in half-seconds equals ramp_seconds
    always_comb begin
        ramp_h = {1'b0, i_cfg.ramp_seconds};
        abs_s  = r_b_ds[ncts_pkg::DIST_W-1] ? ncts_pkg::TIME_W'(-r_b_ds)
                                            : r_b_ds[ncts_pkg::TIME_W-1:0];
        abs_e  = r_b_de[ncts_pkg::DIST_W-1] ? ncts_pkg::TIME_W'(-r_b_de)
                                            : r_b_de[ncts_pkg::TIME_W-1:0];
        near_s = abs_s < ramp_h;
        near_e = abs_e < ramp_h;
        sum_s  = $signed({2'b00, ramp_h}) + $signed({r_b_ds[ncts_pkg::DIST_W-1], r_b_ds});
        sum_e  = $signed({2'b00, ramp_h}) - $signed({r_b_de[ncts_pkg::DIST_W-1], r_b_de});

        o_q_item.kind = r_b_kind;
        o_q_item.num  = '0;
        if (r_b_kind == ncts_pkg::KIND_RAMP) begin
            // follow the nearer end where both ramps cover the time
            if (near_s && (!near_e || abs_s <= abs_e)) begin
                o_q_item.num = sum_s[ncts_pkg::TIME_W-1:0];
            end else if (near_e) begin
                o_q_item.num = sum_e[ncts_pkg::TIME_W-1:0];
            end else begin
                o_q_item.kind = r_b_win ? ncts_pkg::KIND_ONE : ncts_pkg::KIND_ZERO;
            end
        end
    end

endmodule

// ===== rtl/core/ncts_queue.sv =====
// ----------------------------------------------------------------------------
// Night color temperature schedule: queue
// Short first-in first-out buffer of classified beats.
// ----------------------------------------------------------------------------
module ncts_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ncts_pkg::t_mid_item i_item,
    output logic                o_full,
    input  logic                i_pop,
    output ncts_pkg::t_mid_item o_item,
    output logic                o_empty
);

    ncts_pkg::t_mid_item             r_mem [ncts_pkg::QUEUE_DEPTH];
    logic [ncts_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [ncts_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [ncts_pkg::QUEUE_AW:0]     r_count;
    logic [ncts_pkg::QUEUE_AW:0]     n_count;

    assign o_full  = r_count == (ncts_pkg::QUEUE_AW + 1)'(ncts_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/ncts_divider.sv =====
// ----------------------------------------------------------------------------
// Night color temperature schedule: ramp divider
// Pipelined restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ncts_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic                           i_valid,
    input  ncts_pkg::t_mid_item            i_item,
    input  logic [ncts_pkg::RAMP_W-1:0]    i_ramp,
    output logic                           o_valid,
    output ncts_pkg::t_div_result          o_result
);

    // shift in one dividend bit, subtract when it fits; {quotient bit, rest}
    function automatic logic [ncts_pkg::TIME_W:0] div_step(
        input logic [ncts_pkg::TIME_W-1:0] rem,
        input logic                        low_bit,
        input logic [ncts_pkg::TIME_W:0]   divisor
    );
        logic [ncts_pkg::TIME_W:0] shifted;
        logic [ncts_pkg::TIME_W:0] trial;
        shifted = {rem, low_bit};
        trial   = shifted - divisor;
        if (shifted >= divisor) begin
            return {1'b1, trial[ncts_pkg::TIME_W-1:0]};
        end else begin
            return {1'b0, shifted[ncts_pkg::TIME_W-1:0]};
        end
    endfunction

    localparam int LAST = ncts_pkg::DIV_STAGES - 1;

    logic [ncts_pkg::TIME_W:0]       divisor;
    logic [ncts_pkg::TIME_W-1:0]     stage_rem  [ncts_pkg::DIV_STAGES];
    logic [ncts_pkg::QUOT_W-1:0]     stage_quot [ncts_pkg::DIV_STAGES];
    ncts_pkg::t_kind                 stage_kind [ncts_pkg::DIV_STAGES];
    logic [ncts_pkg::TIME_W:0]       n_step     [ncts_pkg::DIV_STAGES];
    logic [ncts_pkg::TIME_W-1:0]     r_rem      [ncts_pkg::DIV_STAGES];
    logic [ncts_pkg::QUOT_W-1:0]     r_quot     [ncts_pkg::DIV_STAGES];
    ncts_pkg::t_kind                 r_kind     [ncts_pkg::DIV_STAGES];
    logic [ncts_pkg::DIV_STAGES-1:0] r_valid;

    // the dividend is num * 2^16 + h over 2h; the low word is h itself
    assign divisor = {1'b0, i_ramp, 1'b0};

    always_comb begin
        stage_rem[0]  = i_item.num;
        stage_quot[0] = '0;
        stage_kind[0] = i_item.kind;
        for (int k = 1; k < ncts_pkg::DIV_STAGES; k++) begin
            stage_rem[k]  = r_rem[k-1];
            stage_quot[k] = r_quot[k-1];
            stage_kind[k] = r_kind[k-1];
        end
        for (int k = 0; k < ncts_pkg::DIV_STAGES; k++) begin
            n_step[k] = div_step(stage_rem[k], i_ramp[LAST-k], divisor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_advance) begin
            r_valid <= {r_valid[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int k = 0; k < ncts_pkg::DIV_STAGES; k++) begin
                r_rem[k]  <= n_step[k][ncts_pkg::TIME_W-1:0];
                r_quot[k] <= {stage_quot[k][ncts_pkg::QUOT_W-2:0],
                              n_step[k][ncts_pkg::TIME_W]};
                r_kind[k] <= stage_kind[k];
            end
        end
    end

    assign o_valid       = r_valid[LAST];
    assign o_result.kind = r_kind[LAST];
    assign o_result.quot = r_quot[LAST];

endmodule

// ===== rtl/core/ncts_back.sv =====
// ----------------------------------------------------------------------------
// Night color temperature schedule: back
// Divide the ramp, interpolate kelvin and hold the result beat.
// ----------------------------------------------------------------------------
module ncts_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ncts_pkg::t_cfg      i_cfg,
    input  logic                i_q_empty,
    input  ncts_pkg::t_mid_item i_q_item,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output ncts_pkg::t_out_item o_result
);

    localparam int PROD_W = 34;
    localparam logic signed [PROD_W-1:0] KELVIN_ROUND = 34'sd32768;

    logic                          back_adv;
    logic                          div_valid;
    ncts_pkg::t_div_result         div_result;

    logic [ncts_pkg::FRAC_W-1:0]   n_m_frac;
    logic signed [ncts_pkg::KELVIN_W:0] temp_gap;
    logic signed [PROD_W-1:0]      n_m_prod;
    logic                          r_m_valid;
    ncts_pkg::t_kind               r_m_kind;
    logic [ncts_pkg::FRAC_W-1:0]   r_m_frac;
    logic signed [PROD_W-1:0]      r_m_prod;

    logic signed [PROD_W-1:0]      acc;
    ncts_pkg::t_out_item           n_out;
    ncts_pkg::t_out_item           r_out;
    logic                          r_out_valid;

    // the whole pipe moves while the result register is free or being taken
    assign back_adv = !r_out_valid || i_pop;
    assign o_q_pop  = back_adv && !i_q_empty;

    ncts_divider u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (back_adv),
        .i_valid   (!i_q_empty),
        .i_item    (i_q_item),
        .i_ramp    (i_cfg.ramp_seconds),
        .o_valid   (div_valid),
        .o_result  (div_result)
    );

    always_comb begin
        case (div_result.kind)
            ncts_pkg::KIND_RAMP: n_m_frac = {1'b0, div_result.quot};
            ncts_pkg::KIND_ONE:  n_m_frac = ncts_pkg::Q_ONE;
            default:             n_m_frac = '0;
        endcase
        temp_gap = $signed({1'b0, i_cfg.night_temperature})
                 - $signed({1'b0, i_cfg.day_temperature});
        n_m_prod = $signed({1'b0, n_m_frac}) * temp_gap;
    end

    always_comb begin
        acc = $signed({3'b000, i_cfg.day_temperature, 16'h0000}) + r_m_prod + KELVIN_ROUND;
        n_out.warm_fraction = r_m_frac;
        if (r_m_kind == ncts_pkg::KIND_NEUTRAL) begin
            n_out.kelvin_out = ncts_pkg::DISABLED_KELVIN;
        end else begin
            n_out.kelvin_out = acc[30:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (back_adv) begin
            r_m_valid   <= div_valid;
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_adv) begin
            r_m_kind <= div_result.kind;
            r_m_frac <= n_m_frac;
            r_m_prod <= n_m_prod;
            r_out    <= n_out;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ===== verif/tb_night_color_temperature_schedule.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Night color temperature schedule testbench
// Drives time-of-day beats through the push/full side and pops kelvin and
// warm-fraction beats, comparing each one against an in-bench schedule
// model. Registers are reprogrammed over APB between phases, always with
// nothing in flight. Both sides idle in random bursts. One long receiver
// hold-off fills the block. The last phase runs at full rate.
// ----------------------------------------------------------------------------
module tb_night_color_temperature_schedule;
    import ncts_pkg::*;

    // Time arithmetic works in whole seconds and half-seconds. Use wide
    // signed math so ramp numerators and kelvin products never wrap.
    localparam longint DAY_LEN     = 86400;
    localparam longint FULL_WARM   = 65536;
    localparam int     LONG_HOLD   = 300;
    localparam int     STALL_LIMIT = 3000;
    localparam int     DRAIN_TAIL  = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    t_in_item              i_item = '0;
    logic                  full;
    logic                  pop = 1'b0;
    t_out_item             o_result;
    logic                  empty;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    night_color_temperature_schedule uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .pop      (pop),
        .o_result (o_result),
        .empty    (empty),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the register file, updated at each APB write edge.
    t_cfg        shadow_cfg = CFG_RESET;
    // Kelvin/fraction beats predicted for accepted inputs, oldest first.
    t_out_item   warmth_due[$];
    int unsigned mismatch_count = 0;
    // Idling knobs; the long hold-off request is consumed by the sink.
    bit          sender_idling = 1'b1;
    bit          sink_idling = 1'b1;
    bit          long_hold_req = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Schedule model
    // ------------------------------------------------------------------

    // Signed clock distance from ref to t in half-seconds, in (-12 h, 12 h].
    function automatic longint half_gap(longint t, longint ref_s);
        longint gap;
        gap = (t + DAY_LEN - ref_s) % DAY_LEN;
        half_gap = gap * 2;
        if (gap > DAY_LEN / 2) begin
            half_gap -= 2 * DAY_LEN;
        end
    endfunction

    // num / (2h) in Q1.16, ties up, clamped to [0, 1].
    function automatic longint ramp_level(longint num, longint h);
        longint v;
        if (num <= 0) begin
            return 0;
        end
        if (num >= 2 * h) begin
            return FULL_WARM;
        end
        v = (num * FULL_WARM + h) / (2 * h);
        return (v > FULL_WARM) ? FULL_WARM : v;
    endfunction

    // Warm level for time t against the window [s, e), ramps centred on
    // each end; the nearer end wins where the ramps overlap.
    function automatic longint window_level(longint t, longint s, longint e);
        longint h, ds, de, ds_abs, de_abs;
        bit     near_s, near_e, in_span;
        h = longint'(shadow_cfg.ramp_seconds);
        if (h > 0) begin
            ds = half_gap(t, s);
            de = half_gap(t, e);
            ds_abs = (ds < 0) ? -ds : ds;
            de_abs = (de < 0) ? -de : de;
            near_s = ds_abs < h;
            near_e = de_abs < h;
            if (near_s && (!near_e || ds_abs <= de_abs)) begin
                return ramp_level(h + ds, h);
            end
            if (near_e) begin
                return ramp_level(h - de, h);
            end
        end
        // Hard switch outside any ramp; an empty window when start equals end.
        if (s == e) begin
            in_span = 1'b0;
        end else if (s < e) begin
            in_span = (t >= s) && (t < e);
        end else begin
            in_span = (t >= s) || (t < e);
        end
        return in_span ? FULL_WARM : 0;
    endfunction

    function automatic t_out_item schedule_warmth(t_in_item it);
        t_out_item r;
        longint    now_s, rise_s, set_s, frac, acc;
        now_s  = longint'(it.now_time) % DAY_LEN;
        rise_s = longint'(it.sunrise_time) % DAY_LEN;
        set_s  = longint'(it.sunset_time) % DAY_LEN;
        if (!shadow_cfg.enabled) begin
            r.kelvin_out    = DISABLED_KELVIN;
            r.warm_fraction = '0;
            return r;
        end
        if (shadow_cfg.manual_mode) begin
            frac = window_level(now_s, longint'(shadow_cfg.from_time) % DAY_LEN,
                                longint'(shadow_cfg.to_time) % DAY_LEN);
        end else if (!shadow_cfg.location_known) begin
            frac = 0;
        end else if (it.sun_condition == SUN_NORMAL) begin
            frac = window_level(now_s, set_s, rise_s);
        end else if (it.sun_condition == SUN_POLAR_NIGHT) begin
            frac = FULL_WARM;
        end else begin
            // polar day and the unused code both read as day
            frac = 0;
        end
        acc = longint'(shadow_cfg.day_temperature) * FULL_WARM
            + frac * (longint'(shadow_cfg.night_temperature)
                      - longint'(shadow_cfg.day_temperature))
            + FULL_WARM / 2;
        if (acc < 0) begin
            acc = 0;
        end
        r.kelvin_out    = KELVIN_W'(acc / FULL_WARM);
        r.warm_fraction = FRAC_W'(frac);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what,
                     want, got);
        end
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (warmth_due.size() == 0) begin
            note_mismatch("unexpected result beat (kelvin_out)", 0, 32'(got.kelvin_out));
            return;
        end
        want = warmth_due.pop_front();
        if (got.kelvin_out !== want.kelvin_out) begin
            note_mismatch("kelvin_out", 32'(want.kelvin_out), 32'(got.kelvin_out));
        end
        if (got.warm_fraction !== want.warm_fraction) begin
            note_mismatch("warm_fraction", 32'(want.warm_fraction), 32'(got.warm_fraction));
        end
    endtask

    // Result sink: check every popped beat, then pick the next pop value.
    // Hold pop low in random bursts, or for one long stretch on request.
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                check_result(o_result);
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                pop <= 1'b0;
            end else if (sink_idling && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 14);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no beat on any port; give up at the limit.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one beat and hold it until accepted; record its prediction.
    // Leave push high so a following beat goes out back to back.
    task automatic send_reading(t_in_item it);
        if (sender_idling && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        warmth_due.push_back(schedule_warmth(it));
    endtask

    // Drop push and wait until every predicted beat has come back.
    task automatic wait_drained();
        push <= 1'b0;
        while (warmth_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] register_value(t_reg_index idx);
        case (idx)
            REG_ENABLED:           return 32'(shadow_cfg.enabled);
            REG_MANUAL_MODE:       return 32'(shadow_cfg.manual_mode);
            REG_LOCATION_KNOWN:    return 32'(shadow_cfg.location_known);
            REG_FROM_TIME:         return 32'(shadow_cfg.from_time);
            REG_TO_TIME:           return 32'(shadow_cfg.to_time);
            REG_DAY_TEMPERATURE:   return 32'(shadow_cfg.day_temperature);
            REG_NIGHT_TEMPERATURE: return 32'(shadow_cfg.night_temperature);
            default:               return 32'(shadow_cfg.ramp_seconds);
        endcase
    endfunction

    // Setup cycle, then access cycle; the register takes the value at the
    // access edge. Idle after so psel falls cleanly.
    task automatic write_register(t_reg_index idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_ENABLED:           shadow_cfg.enabled = value[0];
            REG_MANUAL_MODE:       shadow_cfg.manual_mode = value[0];
            REG_LOCATION_KNOWN:    shadow_cfg.location_known = value[0];
            REG_FROM_TIME:         shadow_cfg.from_time = value[TIME_W-1:0];
            REG_TO_TIME:           shadow_cfg.to_time = value[TIME_W-1:0];
            REG_DAY_TEMPERATURE:   shadow_cfg.day_temperature = value[KELVIN_W-1:0];
            REG_NIGHT_TEMPERATURE: shadow_cfg.night_temperature = value[KELVIN_W-1:0];
            default:               shadow_cfg.ramp_seconds = value[RAMP_W-1:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_register(t_reg_index idx);
        logic [31:0] want;
        want = register_value(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (prdata !== want) begin
            note_mismatch({"prdata of ", idx.name()}, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain, then write every register and read each one back.
    task automatic apply_settings(t_cfg c);
        wait_drained();
        write_register(REG_ENABLED,           32'(c.enabled));
        write_register(REG_MANUAL_MODE,       32'(c.manual_mode));
        write_register(REG_LOCATION_KNOWN,    32'(c.location_known));
        write_register(REG_FROM_TIME,         32'(c.from_time));
        write_register(REG_TO_TIME,           32'(c.to_time));
        write_register(REG_DAY_TEMPERATURE,   32'(c.day_temperature));
        write_register(REG_NIGHT_TEMPERATURE, 32'(c.night_temperature));
        write_register(REG_RAMP_SECONDS,      32'(c.ramp_seconds));
        for (int i = 0; i < 8; i++) begin
            read_register(t_reg_index'(i));
        end
    endtask

    function automatic t_cfg settings(bit en, bit man, bit loc, int from_s, int to_s,
                                      int day_k, int night_k, int ramp_s);
        t_cfg c;
        c.enabled           = en;
        c.manual_mode       = man;
        c.location_known    = loc;
        c.from_time         = TIME_W'(from_s);
        c.to_time           = TIME_W'(to_s);
        c.day_temperature   = KELVIN_W'(day_k);
        c.night_temperature = KELVIN_W'(night_k);
        c.ramp_seconds      = RAMP_W'(ramp_s);
        return c;
    endfunction

    function automatic t_in_item reading(int now_s, logic [1:0] cond, int rise_s, int set_s);
        t_in_item it;
        it.now_time      = TIME_W'(now_s);
        it.sun_condition = cond;
        it.sunrise_time  = TIME_W'(rise_s);
        it.sunset_time   = TIME_W'(set_s);
        return it;
    endfunction

    // Time of day, mostly in range; some past midnight wrap, some at the ends.
    function automatic logic [TIME_W-1:0] random_clock();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return TIME_W'(DAY_LEN - 1);
            2, 3:    return TIME_W'($urandom_range(86400, 131071));
            default: return TIME_W'($urandom_range(0, 86399));
        endcase
    endfunction

    function automatic logic [KELVIN_W-1:0] random_kelvin();
        case ($urandom_range(0, 9))
            0:       return KELVIN_W'(1000);
            1:       return KELVIN_W'(25000);
            2:       return KELVIN_W'($urandom_range(0, 32767));
            default: return KELVIN_W'($urandom_range(1000, 25000));
        endcase
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.enabled        = ($urandom_range(0, 7) != 0);
        c.manual_mode    = 1'($urandom_range(0, 1));
        c.location_known = ($urandom_range(0, 5) != 0);
        c.from_time      = random_clock();
        c.to_time        = ($urandom_range(0, 7) == 0) ? c.from_time : random_clock();
        c.day_temperature   = random_kelvin();
        c.night_temperature = random_kelvin();
        case ($urandom_range(0, 7))
            0:       c.ramp_seconds = '0;
            1:       c.ramp_seconds = RAMP_W'(1);
            2:       c.ramp_seconds = RAMP_W'($urandom_range(2, 300));
            3, 4:    c.ramp_seconds = RAMP_W'($urandom_range(301, 7200));
            5:       c.ramp_seconds = RAMP_W'(43199);
            6:       c.ramp_seconds = RAMP_W'(65535);
            default: c.ramp_seconds = RAMP_W'($urandom_range(0, 65535));
        endcase
        return c;
    endfunction

    // Fold a time into the day; now and then add a day back so the
    // out-of-range encoding of the same instant gets exercised.
    function automatic logic [TIME_W-1:0] fold_clock(longint t);
        longint v;
        v = ((t % DAY_LEN) + DAY_LEN) % DAY_LEN;
        if (v < 131072 - DAY_LEN && $urandom_range(0, 7) == 0) begin
            v += DAY_LEN;
        end
        return TIME_W'(v);
    endfunction

    // Mostly aim now at one end of the active window, within ramp_seconds + 4
    // seconds either side; the rest is plain noise. Some carry odd sun codes.
    function automatic t_in_item random_reading();
        t_in_item it;
        longint   anchor, span, offset;
        it.sunrise_time  = random_clock();
        it.sunset_time   = random_clock();
        it.sun_condition = ($urandom_range(0, 9) < 7) ? SUN_NORMAL
                                                      : 2'($urandom_range(1, 3));
        if (shadow_cfg.manual_mode) begin
            anchor = $urandom_range(0, 1) ? longint'(shadow_cfg.from_time)
                                          : longint'(shadow_cfg.to_time);
        end else begin
            anchor = $urandom_range(0, 1) ? longint'(it.sunset_time)
                                          : longint'(it.sunrise_time);
        end
        if ($urandom_range(0, 7) == 0) begin
            it.now_time = TIME_W'($urandom_range(0, 131071));
        end else begin
            span   = longint'(shadow_cfg.ramp_seconds) + 4;
            offset = longint'($urandom_range(0, 32'(2 * span))) - span;
            it.now_time = fold_clock(anchor + offset);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Read back the reset values of every register.
    task automatic test_register_access();
        for (int i = 0; i < 8; i++) begin
            read_register(t_reg_index'(i));
        end
    endtask

    // Disabled after reset: neutral kelvin and zero fraction for any input.
    task automatic test_disabled_neutral();
        send_reading(reading(0, SUN_NORMAL, 0, 0));
        send_reading(reading(131071, SUN_UNKNOWN, 131071, 131071));
    endtask

    // Manual window 20:00 to 06:00 with one-hour ramps: ramp edges,
    // centres, inside, outside, and a time past the end of the day.
    task automatic test_manual_window();
        apply_settings(settings(1, 1, 0, 72000, 21600, 6500, 4000, 3600));
        send_reading(reading(72000, SUN_POLAR_DAY, 0, 0));
        send_reading(reading(70200, SUN_NORMAL, 0, 0));
        send_reading(reading(73799, SUN_NORMAL, 0, 0));
        send_reading(reading(0, SUN_NORMAL, 0, 0));
        send_reading(reading(43200, SUN_POLAR_NIGHT, 0, 0));
        send_reading(reading(131071, SUN_NORMAL, 0, 0));
        send_reading(reading(21600, SUN_NORMAL, 0, 0));
    endtask

    // Zero ramp: hard switch on a window that wraps midnight, with extreme
    // temperatures; then an empty window where start equals end.
    task automatic test_hard_switch();
        apply_settings(settings(1, 1, 1, 86399, 1, 1000, 25000, 0));
        send_reading(reading(86399, SUN_NORMAL, 0, 0));
        send_reading(reading(0, SUN_NORMAL, 0, 0));
        send_reading(reading(1, SUN_NORMAL, 0, 0));
        send_reading(reading(86398, SUN_NORMAL, 0, 0));
        send_reading(reading(131071, SUN_NORMAL, 0, 0));
        apply_settings(settings(1, 1, 1, 500, 500, 1000, 25000, 0));
        send_reading(reading(500, SUN_NORMAL, 0, 0));
    endtask

    // Sun mode with a 43199-second ramp: normal sun, equal sunrise and
    // sunset, both polar cases, the unused code, then an unknown location.
    task automatic test_sun_schedule();
        apply_settings(settings(1, 0, 1, 0, 0, 25000, 1000, 43199));
        send_reading(reading(0, SUN_NORMAL, 86399, 0));
        send_reading(reading(43200, SUN_NORMAL, 43200, 43200));
        send_reading(reading(100000, SUN_NORMAL, 131071, 90000));
        send_reading(reading(3000, SUN_POLAR_DAY, 20000, 70000));
        send_reading(reading(3000, SUN_POLAR_NIGHT, 20000, 70000));
        send_reading(reading(3000, SUN_UNKNOWN, 20000, 70000));
        apply_settings(settings(1, 0, 0, 0, 0, 25000, 1000, 43199));
        send_reading(reading(3000, SUN_POLAR_NIGHT, 20000, 70000));
    endtask

    // Random phases, the first two at extreme field values.
    task automatic test_random_schedules();
        t_cfg c;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0) begin
                c = settings(1, 1, 1, 0, 86399, 1000, 25000, 1);
            end else if (phase == 1) begin
                c = settings(1, 1, 1, 131071, 0, 32767, 0, 65535);
            end else begin
                c = random_settings();
            end
            apply_settings(c);
            repeat (75) send_reading(random_reading());
        end
    endtask

    // Hold the sink off for a long stretch while beats keep coming, so the
    // block fills and raises full.
    task automatic test_backpressure();
        t_cfg c;
        c = random_settings();
        c.enabled = 1'b1;
        apply_settings(c);
        sender_idling = 1'b0;
        long_hold_req = 1'b1;
        repeat (60) send_reading(random_reading());
        sender_idling = 1'b1;
    endtask

    // Closing phase: no idling on either side.
    task automatic test_full_rate();
        t_cfg c;
        c = random_settings();
        c.enabled = 1'b1;
        sender_idling = 1'b0;
        sink_idling   = 1'b0;
        apply_settings(c);
        repeat (90) send_reading(random_reading());
    endtask

    initial begin : run
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_disabled_neutral();
        test_manual_window();
        test_hard_switch();
        test_sun_schedule();
        test_random_schedules();
        test_backpressure();
        test_full_rate();
        wait_drained();
        // let any stray beat surface before the verdict
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatch_count == 0 && warmth_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
